>>> design/brb_pkg.sv
// Package for the byte ring buffer: sizes, opcodes, transaction and RAM port types.
// No dependencies; imported by every module of the block.
package brb_pkg;

  // Ring depth; one slot always stays empty, so at most SIZE-1 bytes are held.
  localparam int SIZE   = 64;
  localparam int AW     = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int RUN_W  = 6;
  localparam int BYTE_W = 8;
  // Width for fill/free arithmetic and compares against run_length.
  localparam int CMPW   = ((AW > RUN_W) ? AW : RUN_W) + 1;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_PEEK  = 2'd1,
    OP_POP   = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Input transaction.
  typedef struct packed {
    op_t               op;
    logic [RUN_W-1:0]  run_length;
    logic [BYTE_W-1:0] data_in;
    logic              run_end;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              data_valid;
    logic              ok;
    logic              last;
    logic [RUN_W-1:0]  fill_level;
    logic [RUN_W-1:0]  free_space;
    logic              is_empty;
    logic              is_full;
  } out_t;

  // Controller to byte store.
  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [AW-1:0]     raddr;
  } mem_req_t;

endpackage

>>> design/byte_ring_buffer_atomic_runs_top.sv
// Top level of the byte ring buffer with all-or-nothing push runs.
// Depends on brb_pkg, brb_ram and brb_ctrl.
//
// A transaction is taken at a clock edge with start high and busy low. Every
// result is shown on out_item for exactly one cycle with out_strobe high,
// starting the cycle after the transaction (or the read) that causes it; the
// receiver cannot stall, so it must take each result as it appears. A push
// byte, a clear, a zero-length or rejected peek/pop leave busy low, so pushes
// stream at one byte per cycle. A peek or pop of n bytes holds busy while it
// reads one byte per cycle through the single read port of the byte store and
// yields n results. The store holds SIZE-1 bytes at most and needs no clearing
// after reset.
module byte_ring_buffer_atomic_runs_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  brb_pkg::in_t  in_item,
  output logic          out_strobe,
  output brb_pkg::out_t out_item
);
  import brb_pkg::*;

  mem_req_t          mem_req;
  logic [BYTE_W-1:0] rdata;
  out_t              res;
  logic              res_strobe;

  brb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .res_strobe (res_strobe),
    .res        (res),
    .mem_req    (mem_req)
  );

  brb_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // Read data joins the result only for byte results
  always_comb begin
    out_item          = res;
    out_item.data_out = res.data_valid ? rdata : '0;
  end
  assign out_strobe = res_strobe;

`ifndef SYNTHESIS
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !mem_req.we)
    else $error("byte store written during a read run");

  a_valid_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.data_valid) |-> out_item.ok)
    else $error("byte result without ok");

  a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.is_empty) |-> (out_item.fill_level == '0))
    else $error("empty status with nonzero fill");

  a_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_strobe && out_item.last && out_item.data_valid))
    else $error("read run ended without its last byte result");
`endif

endmodule

>>> design/brb_ram.sv
// Byte store of the ring buffer: one write port, one registered read port.
// Depends on brb_pkg for depth and the request struct.
module brb_ram (
  input  logic                     clk,
  input  brb_pkg::mem_req_t        req,
  output logic [brb_pkg::BYTE_W-1:0] rdata
);
  import brb_pkg::*;

  logic [BYTE_W-1:0] mem [SIZE];
  logic [BYTE_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/brb_ctrl.sv
// Ring buffer controller: head/tail pointers, push run tracking, read sequencer.
// Depends on brb_pkg; drives the byte store request and the result register.
module brb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  brb_pkg::in_t      in_item,
  output logic              res_strobe,
  output brb_pkg::out_t     res,
  output brb_pkg::mem_req_t mem_req
);
  import brb_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    wp_r, wp_nxt;
  logic [AW-1:0]    rp_r, rp_nxt;
  logic [AW-1:0]    pend_r, pend_nxt;
  logic             in_run_r, in_run_nxt;
  logic             acc_r, acc_nxt;
  logic [RUN_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic             strobe_r, strobe_nxt;
  out_t             res_r, res_nxt;

  logic             accept;
  logic             push_ok;
  logic [AW-1:0]    push_ptr;
  logic [AW-1:0]    push_ptr_inc;
  logic             push_wr;
  logic [CMPW-1:0]  fill_now;
  logic [CMPW-1:0]  len_ext;

  // Pointer increment modulo SIZE
  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == AW'(SIZE - 1)) r = '0;
    else                    r = p + AW'(1);
    return r;
  endfunction

  // Pointer advance by n < SIZE, one compare and subtract
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p,
                                             input logic [RUN_W-1:0] n);
    logic [CMPW-1:0] s;
    s = CMPW'(p) + CMPW'(n);
    if (s >= CMPW'(SIZE)) s = s - CMPW'(SIZE);
    return s[AW-1:0];
  endfunction

  // Bytes held between tail and head
  function automatic logic [CMPW-1:0] fill_of(input logic [AW-1:0] w,
                                             input logic [AW-1:0] r);
    logic [CMPW-1:0] f;
    if (w >= r) f = CMPW'(w) - CMPW'(r);
    else        f = CMPW'(SIZE) + CMPW'(w) - CMPW'(r);
    return f;
  endfunction

  // Status part of a result, from committed pointers
  function automatic out_t status(input logic [AW-1:0] w, input logic [AW-1:0] r,
                                 input logic valid, input logic okv,
                                 input logic lastv);
    out_t            o;
    logic [CMPW-1:0] f;
    logic [CMPW-1:0] fr;
    f            = fill_of(w, r);
    fr           = CMPW'(SIZE - 1) - f;
    o.data_out   = '0;
    o.data_valid = valid;
    o.ok         = okv;
    o.last       = lastv;
    o.fill_level = f[RUN_W-1:0];
    o.free_space = fr[RUN_W-1:0];
    o.is_empty   = (w == r);
    o.is_full    = (wrap_inc(w) == r);
    return o;
  endfunction

  assign busy     = (state_r == S_RUN);
  assign accept   = start && !busy;
  assign fill_now = fill_of(wp_r, rp_r);
  assign len_ext  = CMPW'(in_item.run_length);

  // Push run: acceptance decided at the first item, pending head tracked per byte
  assign push_ok      = in_run_r ? acc_r
                                 : ((CMPW'(SIZE - 1) - fill_now) >= len_ext);
  assign push_ptr     = in_run_r ? pend_r : wp_r;
  assign push_ptr_inc = wrap_inc(push_ptr);
  assign push_wr      = accept && (in_item.op == OP_PUSH) && push_ok
                        && (push_ptr_inc != rp_r);

  // Byte store requests
  always_comb begin
    mem_req.we    = push_wr;
    mem_req.waddr = push_ptr;
    mem_req.wdata = in_item.data_in;
    mem_req.re    = (state_r == S_RUN);
    mem_req.raddr = addr_r;
  end

  // Next state
  always_comb begin
    state_nxt  = state_r;
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    pend_nxt   = pend_r;
    in_run_nxt = in_run_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    addr_nxt   = addr_r;
    strobe_nxt = 1'b0;
    res_nxt    = res_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          strobe_nxt = 1'b1;
          if (in_item.op == OP_PUSH) begin
            pend_nxt = push_wr ? push_ptr_inc : push_ptr;
            if (in_item.run_end) begin
              if (push_ok) wp_nxt = pend_nxt;
              in_run_nxt = 1'b0;
              acc_nxt    = 1'b0;
            end else begin
              in_run_nxt = 1'b1;
              acc_nxt    = push_ok;
            end
            res_nxt = status(wp_nxt, rp_r, 1'b0, push_ok, in_item.run_end);
          end else begin
            // any other op drops an unfinished push run
            in_run_nxt = 1'b0;
            acc_nxt    = 1'b0;
            priority if (in_item.op == OP_CLEAR) begin
              wp_nxt  = '0;
              rp_nxt  = '0;
              res_nxt = status('0, '0, 1'b0, 1'b1, 1'b1);
            end else if (fill_now < len_ext) begin
              res_nxt = status(wp_r, rp_r, 1'b0, 1'b0, 1'b1);
            end else if (in_item.run_length == '0) begin
              res_nxt = status(wp_r, rp_r, 1'b0, 1'b1, 1'b1);
            end else begin
              // byte run: results come from the read sequencer
              strobe_nxt = 1'b0;
              state_nxt  = S_RUN;
              cnt_nxt    = in_item.run_length;
              addr_nxt   = rp_r;
              if (in_item.op == OP_POP) rp_nxt = wrap_add(rp_r, in_item.run_length);
            end
          end
        end
      end
      S_RUN: begin
        // one byte read per cycle, result shows with the read data
        strobe_nxt = 1'b1;
        addr_nxt   = wrap_inc(addr_r);
        cnt_nxt    = cnt_r - RUN_W'(1);
        res_nxt    = status(wp_r, rp_r, 1'b1, 1'b1, cnt_r == RUN_W'(1));
        if (cnt_r == RUN_W'(1)) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wp_r     <= '0;
      rp_r     <= '0;
      pend_r   <= '0;
      in_run_r <= 1'b0;
      acc_r    <= 1'b0;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      pend_r   <= pend_nxt;
      in_run_r <= in_run_nxt;
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
    end
    addr_r <= addr_nxt;
    res_r  <= res_nxt;
  end

  assign res_strobe = strobe_r;
  assign res        = res_r;

endmodule
